@@ design/egw_pkg.sv @@
// ---------------------------------------------------------------------------
// egw_pkg
// shared types and codes for the exp-golomb bit writer
// ---------------------------------------------------------------------------
package egw_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int PAT_W       = 64;

    typedef logic [2:0]         kind_t;
    typedef logic [30:0]        value_t;
    typedef logic signed [30:0] svalue_t;
    typedef logic [5:0]         count_t;
    typedef logic [7:0]         byte_t;

    localparam kind_t KIND_RAW   = 3'd0;
    localparam kind_t KIND_UE    = 3'd1;
    localparam kind_t KIND_SE    = 3'd2;
    localparam kind_t KIND_FLUSH = 3'd3;
    localparam kind_t KIND_CLEAR = 3'd4;

endpackage

@@ design/egw_in_if.sv @@
// ---------------------------------------------------------------------------
// egw_in_if
// valid/ready channel carrying one syntax element to the bit writer
// ---------------------------------------------------------------------------
interface egw_in_if;
    import egw_pkg::*;

    logic    valid;
    logic    ready;
    kind_t   kind;
    value_t  value;
    svalue_t signed_value;
    count_t  bit_count;

    modport source (output valid, output kind, output value, output signed_value,
                    output bit_count, input ready);
    modport sink   (input valid, input kind, input value, input signed_value,
                    input bit_count, output ready);
endinterface

@@ design/egw_out_if.sv @@
// ---------------------------------------------------------------------------
// egw_out_if
// valid/ready channel carrying one completed stream byte
// ---------------------------------------------------------------------------
interface egw_out_if;
    import egw_pkg::*;

    logic  valid;
    logic  ready;
    byte_t out_byte;
    logic  last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

@@ design/exp_golomb_bit_writer_core.sv @@
// ---------------------------------------------------------------------------
// exp_golomb_bit_writer_core
// packs raw bits and ue/se exp-golomb codes msb first into stream bytes
// ---------------------------------------------------------------------------
// One element is taken at a time; the block is ready again once the element's
// last bit is packed. Once accepted, a ue or se element runs a binary search
// for the leading one over shifts of 16, 8, 4, 2 and 1 bits, and every element
// with bits is packed in chunks into the partial byte: a chunk fills the
// partial byte or ends the code. A single 64-bit right shifter does both the
// search and the chunk extraction. A full byte waits in the output register;
// packing stalls only when a chunk would complete a byte while that register
// still holds a byte the sink has not taken. A clear item empties the partial
// byte when accepted and emits no byte.
module exp_golomb_bit_writer_core
(
    input  logic             clk,
    input  logic             rst_n,
    egw_in_if.sink           item,
    egw_out_if.source        result
);
    import egw_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_FIND = 2'd1;
    localparam logic [1:0] ST_PACK = 2'd2;

    logic [1:0]       state_reg,  state_next;
    logic [2:0]       step_reg,   step_next;
    logic [4:0]       lz_reg,     lz_next;
    logic [31:0]      norm_reg,   norm_next;
    logic [PAT_W-1:0] pat_reg,    pat_next;
    logic [5:0]       rem_reg,    rem_next;
    logic [6:0]       pbits_reg,  pbits_next;
    logic [2:0]       pcount_reg, pcount_next;
    logic             ovalid_reg, ovalid_next;
    byte_t            obyte_reg,  obyte_next;
    logic             olast_reg,  olast_next;

    // shared shifter
    logic [PAT_W-1:0] sh_in;
    logic [5:0]       sh_amt;
    logic [PAT_W-1:0] sh_out;

    logic [5:0]  find_amt;
    logic        find_hit;
    logic [3:0]  free_bits;
    logic [3:0]  take;
    logic [5:0]  rem_after;
    logic [7:0]  take_mask;
    logic [7:0]  merged;
    logic [3:0]  fill;
    logic        byte_full;
    logic        out_free;
    logic        byte_load;
    logic [5:0]  raw_count;
    logic [29:0] se_abs;
    logic        se_nonpos;

    assign sh_out = sh_in >> sh_amt;

    assign find_amt  = 6'd16 >> step_reg;
    assign find_hit  = sh_out[31:0] != 32'd0;

    assign free_bits = 4'd8 - {1'b0, pcount_reg};
    assign take      = (rem_reg < {2'b00, free_bits}) ? rem_reg[3:0] : free_bits;
    assign rem_after = rem_reg - {2'b00, take};
    assign take_mask = 8'hFF >> (4'd8 - take);
    assign merged    = (8'({1'b0, pbits_reg}) << take) | (sh_out[7:0] & take_mask);
    assign fill      = {1'b0, pcount_reg} + take;
    assign byte_full = fill == 4'd8;
    assign out_free  = !ovalid_reg || result.ready;
    assign byte_load = (state_reg == ST_PACK) && byte_full && out_free;

    assign raw_count = (item.bit_count > 6'(VALUE_WIDTH)) ? 6'(VALUE_WIDTH) : item.bit_count;

    // clamp the most negative value, then magnitude
    always_comb
    begin
        if (item.signed_value == 31'sh4000_0000)
        begin
            se_abs = 30'h3FFF_FFFF;
        end
        else if (item.signed_value[30])
        begin
            se_abs = 30'(-item.signed_value);
        end
        else
        begin
            se_abs = item.signed_value[29:0];
        end
    end
    assign se_nonpos = item.signed_value[30] || (item.signed_value == 31'sd0);

    always_comb
    begin
        if (state_reg == ST_FIND)
        begin
            sh_in  = {32'd0, norm_reg};
            sh_amt = find_amt;
        end
        else
        begin
            sh_in  = pat_reg;
            sh_amt = rem_after;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        lz_next     = lz_reg;
        norm_next   = norm_reg;
        pat_next    = pat_reg;
        rem_next    = rem_reg;
        pbits_next  = pbits_reg;
        pcount_next = pcount_reg;
        ovalid_next = ovalid_reg && !result.ready;
        obyte_next  = obyte_reg;
        olast_next  = olast_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    step_next = 3'd0;
                    lz_next   = 5'd0;
                    case (item.kind)
                        KIND_RAW:
                        begin
                            pat_next = {33'd0, item.value};
                            rem_next = raw_count;
                            if (raw_count != 6'd0)
                            begin
                                state_next = ST_PACK;
                            end
                        end
                        KIND_UE:
                        begin
                            norm_next  = {1'b0, item.value} + 32'd1;
                            pat_next   = {32'd0, norm_next};
                            state_next = ST_FIND;
                        end
                        KIND_SE:
                        begin
                            norm_next  = {1'b0, se_abs, se_nonpos};
                            pat_next   = {32'd0, norm_next};
                            state_next = ST_FIND;
                        end
                        KIND_FLUSH:
                        begin
                            pat_next   = {56'd0, 8'h80 >> pcount_reg};
                            rem_next   = {2'b00, free_bits};
                            state_next = ST_PACK;
                        end
                        default:
                        begin
                            pbits_next  = 7'd0;
                            pcount_next = 3'd0;
                        end
                    endcase
                end
            end
            ST_FIND:
            begin
                if (find_hit)
                begin
                    norm_next = sh_out[31:0];
                    lz_next   = lz_reg + find_amt[4:0];
                end
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd4)
                begin
                    rem_next   = {lz_next, 1'b1};
                    state_next = ST_PACK;
                end
            end
            ST_PACK:
            begin
                if (!byte_full || out_free)
                begin
                    rem_next = rem_after;
                    if (byte_full)
                    begin
                        ovalid_next = 1'b1;
                        obyte_next  = merged;
                        olast_next  = rem_after < 6'd8;
                        pbits_next  = 7'd0;
                        pcount_next = 3'd0;
                    end
                    else
                    begin
                        pbits_next  = merged[6:0];
                        pcount_next = fill[2:0];
                    end
                    if (rem_after == 6'd0)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            step_reg   <= 3'd0;
            pbits_reg  <= 7'd0;
            pcount_reg <= 3'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            pbits_reg  <= pbits_next;
            pcount_reg <= pcount_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lz_reg    <= lz_next;
        norm_reg  <= norm_next;
        pat_reg   <= pat_next;
        rem_reg   <= rem_next;
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
    end

    assign item.ready      = state_reg == ST_IDLE;
    assign result.valid    = ovalid_reg;
    assign result.out_byte = obyte_reg;
    assign result.last     = olast_reg;

    // checks
    a_pack_has_bits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PACK |-> rem_reg != 6'd0)
        else $error("pack state entered with no bits left");

    a_find_steps: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FIND |-> step_reg <= 3'd4)
        else $error("leading one search ran past its last step");

    a_find_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FIND |-> norm_reg != 32'd0)
        else $error("leading one search on a zero word");

    a_byte_clears: assert property (@(posedge clk) disable iff (!rst_n)
        byte_load |=> pcount_reg == 3'd0 && ovalid_reg)
        else $error("completed byte did not empty the partial byte");

endmodule
